>>> rtl/sorted_table_binary_search_core_macros.svh
// Assertion macros for the sorted table binary search core.
// Included by RTL files that carry concurrent checks; no dependencies.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define STBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search core.
// No dependencies; imported by the interfaces, stbs_cmp and the core.
package stbs_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned ModeW  = 2;
  // search bounds run from -1 to 511, their sum up to 1022
  localparam int unsigned PtrW   = 11;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [ModeW-1:0] ModeLower = 2'd0;
  localparam logic [ModeW-1:0] ModeUpper = 2'd1;
  localparam logic [ModeW-1:0] ModeExact = 2'd2;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

>>> rtl/stbs_if.sv
// Handshake interfaces for the query/write channel and the result channel.
// Depends on stbs_pkg.
interface stbs_query_if import stbs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [IdxW-1:0]        entry_index;
  logic signed [KeyW-1:0] key_value;
  logic [ModeW-1:0]       search_mode;

  modport source (output valid, op, entry_index, key_value, search_mode, input ready);
  modport sink   (input valid, op, entry_index, key_value, search_mode, output ready);
endinterface

interface stbs_result_if import stbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] position;
  logic              found;

  modport source (output valid, position, found, input ready);
  modport sink   (input valid, position, found, output ready);
endinterface

>>> rtl/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stbs_cmp.sv
// Shared signed key comparator used by every probe of the search.
// Depends on stbs_pkg.
module stbs_cmp import stbs_pkg::*; (
  input  logic signed [KeyW-1:0] entry_i,
  input  logic signed [KeyW-1:0] key_i,
  output cmp_t                   cmp_o
);

  assign cmp_o.lt = (entry_i < key_i);
  assign cmp_o.eq = (entry_i == key_i);

endmodule

>>> rtl/sorted_table_binary_search_core.sv
// Sorted table binary search core: table RAM, probe sequencer, result register.
// Depends on stbs_pkg, stbs_if, stbs_ram, stbs_cmp and the assertion macros.
//
// Usage:
//   query_i carries transactions of two kinds. op = write stores key_value at
//   entry_index (ignored beyond the table depth) and gives no result; the
//   channel stays ready. op = query runs one binary search over the first
//   table_count entries (at most the table depth) and gives one result
//   transaction on result_o (position, found).
//   cfg_we_i/cfg_wdata_i load table_count; write it only while no query runs.
//   Each probe is a registered RAM read followed by one compare.
//   A query runs P probes before its result is registered; an exact hit ends
//   the search at the matching probe, and the unused mode gives its result
//   with no probe. P is at most ceil(log2(n+1)). The next query is accepted
//   from the cycle in which the result becomes valid.
//   query_i is not ready while a query is in flight.
//   Writes may be accepted while a result waits on result_o; a finished query
//   holds in its last state until the result register is free, so a stalled
//   receiver stalls new queries but loses nothing.
//   Reset clears table_count and the control state; table contents are not
//   cleared and must be written before they are searched.
`include "sorted_table_binary_search_core_macros.svh"

module sorted_table_binary_search_core import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  stbs_query_if.sink        query_i,
  stbs_result_if.source     result_o
);

  localparam int unsigned AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CountMax = (1 << CountW) - 1;
  localparam int unsigned DepthCap = (TABLE_DEPTH > CountMax) ? CountMax : TABLE_DEPTH;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_CMP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0]      count_q;
  logic [CountW-1:0]      eff_count;
  logic [ModeW-1:0]       mode_q, mode_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [PtrW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CountW-1:0]      res_pos_q, res_pos_d;
  logic                   res_found_q, res_found_d;
  logic                   out_valid_q, out_valid_d;
  logic [CountW-1:0]      out_pos_q, out_pos_d;
  logic                   out_found_q, out_found_d;

  logic                   in_fire;
  logic                   is_exact;
  logic                   go_on;
  logic signed [PtrW-1:0] mid_bound, mid_exact, mid_next;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [KeyW-1:0]        ram_rdata;
  logic [PtrW-1:0]        mid_u;
  cmp_t                   cmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign eff_count = (count_q > CountW'(DepthCap)) ? CountW'(DepthCap) : count_q;

  assign query_i.ready = (state_q == S_IDLE);
  assign in_fire       = query_i.valid && query_i.ready;

  // table writes go straight to the RAM from the channel
  assign ram_we    = in_fire && (query_i.op == OpWrite)
                     && (32'(query_i.entry_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(query_i.entry_index);
  assign mid_u     = $unsigned(mid_next);
  assign ram_raddr = AW'(mid_u);

  stbs_ram #(
    .WIDTH (KeyW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (query_i.key_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stbs_cmp u_cmp (
    .entry_i (ram_rdata),
    .key_i   (key_q),
    .cmp_o   (cmp)
  );

  assign is_exact  = (mode_q == ModeExact);
  assign mid_bound = (lo_q + hi_q) >>> 1;
  assign mid_exact = lo_q + ((hi_q - lo_q) >>> 1);
  assign mid_next  = is_exact ? mid_exact : mid_bound;
  // bound modes search the open interval (lo, hi), exact mode the closed one
  assign go_on     = is_exact ? (lo_q <= hi_q) : ((hi_q - lo_q) > PtrW'(1));

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_found_d = out_found_q;

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire && (query_i.op == OpQuery)) begin
          mode_d      = query_i.search_mode;
          key_d       = query_i.key_value;
          res_pos_d   = '0;
          res_found_d = 1'b0;
          if (query_i.search_mode == ModeExact) begin
            lo_d = '0;
            hi_d = $signed(PtrW'(eff_count)) - PtrW'(1);
          end else begin
            lo_d = -PtrW'(1);
            hi_d = $signed(PtrW'(eff_count));
          end
          if (query_i.search_mode inside {ModeLower, ModeUpper, ModeExact}) begin
            state_d = S_CHECK;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CHECK: begin
        if (go_on) begin
          mid_d   = mid_next;
          state_d = S_CMP;
        end else begin
          if (!is_exact) begin
            res_pos_d = hi_q[CountW-1:0];
          end
          state_d = S_DONE;
        end
      end
      S_CMP: begin
        state_d = S_CHECK;
        if (is_exact) begin
          if (cmp.eq) begin
            res_pos_d   = mid_q[CountW-1:0];
            res_found_d = 1'b1;
            state_d     = S_DONE;
          end else if (cmp.lt) begin
            lo_d = mid_q + PtrW'(1);
          end else begin
            hi_d = mid_q - PtrW'(1);
          end
        end else if (cmp.lt || ((mode_q == ModeUpper) && cmp.eq)) begin
          lo_d = mid_q;
        end else begin
          hi_d = mid_q;
        end
      end
      S_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = res_pos_q;
          out_found_d = res_found_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    out_pos_q   <= out_pos_d;
    out_found_q <= out_found_d;
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.position = out_pos_q;
  assign result_o.found    = out_found_q;

  `STBS_ASSERT_NXT(a_query_leaves_idle, clk_i, rst_ni,
                   in_fire && (query_i.op == OpQuery), state_q != S_IDLE,
                   "query transaction did not start a search")
  `STBS_ASSERT_NXT(a_write_stays_idle, clk_i, rst_ni,
                   in_fire && (query_i.op == OpWrite), state_q == S_IDLE,
                   "write transaction left idle")
  `STBS_ASSERT_IMP(a_probe_in_range, clk_i, rst_ni,
                   state_q == S_CMP, (lo_q <= mid_q) && (mid_q <= hi_q),
                   "probe index outside search interval")
  `STBS_ASSERT_IMP(a_result_from_done, clk_i, rst_ni,
                   $rose(out_valid_q), $past(state_q == S_DONE),
                   "result raised outside completion state")

endmodule
